/* sv/continued_fraction_convergents_macros.svh */
// Assertion macros for the continued fraction convergents block.
`ifndef CONTINUED_FRACTION_CONVERGENTS_MACROS_SVH
`define CONTINUED_FRACTION_CONVERGENTS_MACROS_SVH
`ifndef SYNTHESIS
`define CFC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfc assertion failed");
`define CFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfc assertion failed");
`else
`define CFC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CFC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/cfc_pkg.sv */
// Shared types and constants for the continued fraction convergents block.
package cfc_pkg;
   localparam int CFC_WIDTH       = 32;
   localparam int CFC_MAX_RESULTS = 48;

   typedef enum logic [1:0] {
      CFC_IDLE,
      CFC_DIV,
      CFC_EMIT
   } cfc_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic emit;
      logic last;
   } cfc_cmd_type;

   typedef struct packed {
      logic rem_zero;
   } cfc_status_type;
endpackage

/* sv/cfc_ctrl.sv */
// Controller: sequences load, divide steps and convergent updates.
`include "continued_fraction_convergents_macros.svh"
module cfc_ctrl #(
   parameter int WIDTH = cfc_pkg::CFC_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  cfc_pkg::cfc_status_type status,
   output cfc_pkg::cfc_cmd_type    cmd
);
   import cfc_pkg::*;

   localparam int VW = ((WIDTH > 32) ? WIDTH : 32) + 1;
   localparam int CW = $clog2(VW);
   localparam int RW = $clog2(CFC_MAX_RESULTS);

   cfc_state_type   state_ff, state_in;
   logic [CW-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [RW-1:0]   res_cnt_ff, res_cnt_in;
   logic            fin;

   assign fin = status.rem_zero || (res_cnt_ff == RW'(CFC_MAX_RESULTS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CFC_IDLE: begin
            if (start) state_in = CFC_DIV;
         end
         CFC_DIV: begin
            if (bit_cnt_ff == '0) state_in = CFC_EMIT;
         end
         CFC_EMIT: begin
            state_in = fin ? CFC_IDLE : CFC_DIV;
         end
         default: state_in = CFC_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      bit_cnt_in = bit_cnt_ff;
      res_cnt_in = res_cnt_ff;
      case (state_ff)
         CFC_IDLE: begin
            busy       = 1'b0;
            cmd.load   = start;
            bit_cnt_in = CW'(VW - 1);
            res_cnt_in = '0;
         end
         CFC_DIV: begin
            cmd.div_step = 1'b1;
            bit_cnt_in   = bit_cnt_ff - 1'b1;
         end
         CFC_EMIT: begin
            cmd.emit   = 1'b1;
            cmd.last   = fin;
            bit_cnt_in = CW'(VW - 1);
            res_cnt_in = res_cnt_ff + 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CFC_IDLE;
         bit_cnt_ff <= '0;
         res_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   `CFC_ASSERT_NEXT(a_last_to_idle, clock, reset, cmd.emit && cmd.last, !busy)
   `CFC_ASSERT_NEXT(a_load_to_div, clock, reset, cmd.load, state_ff == CFC_DIV)
   `CFC_ASSERT_IMPLY(a_res_cnt_bound, clock, reset, state_ff == CFC_DIV,
                     res_cnt_ff < RW'(CFC_MAX_RESULTS))
endmodule

/* sv/cfc_dp.sv */
// Datapath: restoring divider with shift-add convergent recurrence and result registers.
`include "continued_fraction_convergents_macros.svh"
module cfc_dp #(
   parameter int WIDTH = cfc_pkg::CFC_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfc_pkg::cfc_cmd_type    cmd,
   output cfc_pkg::cfc_status_type status,
   input  logic [31:0]             req_numerator,
   input  logic [5:0]              req_exponent,
   output logic                    rsp_valid,
   output logic [32:0]             rsp_quotient,
   output logic [31:0]             rsp_conv_numer,
   output logic [32:0]             rsp_conv_denom,
   output logic                    rsp_candidate,
   output logic                    rsp_last
);
   import cfc_pkg::*;

   localparam int VW = ((WIDTH > 32) ? WIDTH : 32) + 1;
   localparam logic [63:0] XMASK = (64'd1 << WIDTH) - 64'd1;
   localparam logic [5:0]  NMAX  = 6'(WIDTH);

   logic [VW-1:0] a_ff, rem_ff, b_ff, qt_ff, accp_ff, accq_ff;
   logic [VW-1:0] p1_ff, p2_ff, q1_ff, q2_ff, bound_ff;
   logic          valid_ff;
   logic [32:0]   quot_ff, denom_ff;
   logic [31:0]   numer_ff;
   logic          cand_ff, last_ff;

   logic [5:0]    nexp;
   logic [VW:0]   trial;
   logic          qbit;
   logic [VW-1:0] rem_in, pj, qj;

   assign nexp  = (req_exponent > NMAX) ? NMAX : req_exponent;
   assign trial = {rem_ff, a_ff[VW-1]};
   assign qbit  = (trial >= {1'b0, b_ff});
   assign rem_in = qbit ? VW'(trial - {1'b0, b_ff}) : trial[VW-1:0];
   assign pj = accp_ff + p2_ff;
   assign qj = accq_ff + q2_ff;
   assign status.rem_zero = (rem_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff     <= VW'(req_numerator & XMASK[31:0]);
         b_ff     <= VW'(1) << nexp;
         bound_ff <= VW'(1) << nexp[5:1];
         rem_ff   <= '0;
         qt_ff    <= '0;
         accp_ff  <= '0;
         accq_ff  <= '0;
         p2_ff    <= '0;
         p1_ff    <= VW'(1);
         q2_ff    <= VW'(1);
         q1_ff    <= '0;
      end else if (cmd.div_step) begin
         a_ff    <= {a_ff[VW-2:0], 1'b0};
         rem_ff  <= rem_in;
         qt_ff   <= {qt_ff[VW-2:0], qbit};
         // Horner form of qt * p(j-1) and qt * q(j-1), one quotient bit per cycle
         accp_ff <= {accp_ff[VW-2:0], 1'b0} + (qbit ? p1_ff : '0);
         accq_ff <= {accq_ff[VW-2:0], 1'b0} + (qbit ? q1_ff : '0);
      end else if (cmd.emit) begin
         a_ff    <= b_ff;
         b_ff    <= rem_ff;
         rem_ff  <= '0;
         qt_ff   <= '0;
         accp_ff <= '0;
         accq_ff <= '0;
         p2_ff   <= p1_ff;
         p1_ff   <= pj;
         q2_ff   <= q1_ff;
         q1_ff   <= qj;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         quot_ff  <= qt_ff[32:0];
         numer_ff <= pj[31:0];
         denom_ff <= qj[32:0];
         cand_ff  <= (qj <= bound_ff);
         last_ff  <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= cmd.emit;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_quotient   = quot_ff;
   assign rsp_conv_numer = numer_ff;
   assign rsp_conv_denom = denom_ff;
   assign rsp_candidate  = cand_ff;
   assign rsp_last       = last_ff;

   `CFC_ASSERT_IMPLY(a_divisor_nonzero, clock, reset, cmd.div_step, b_ff != '0)
   `CFC_ASSERT_IMPLY(a_rem_below_divisor, clock, reset, cmd.div_step, rem_ff < b_ff)
   `CFC_ASSERT_IMPLY(a_denom_nonzero, clock, reset, valid_ff, q1_ff != '0)
endmodule

/* sv/continued_fraction_convergents.sv */
// Top level of the continued fraction convergents block.
// Usage: pulse start with req_numerator (x) and req_exponent (n) while busy is low;
// the item is taken at that edge and busy rises on the next cycle. The block expands
// x / 2^n by Euclid's steps and emits one result per partial quotient: rsp_valid is
// high for exactly one cycle with rsp_quotient, the convergent rsp_conv_numer /
// rsp_conv_denom, rsp_candidate (denominator <= 2^floor(n/2)) and rsp_last on the
// final convergent. n above WIDTH is clamped to WIDTH; x keeps its low WIDTH bits.
// Each Euclid step runs on one shared restoring divider, one quotient bit per cycle,
// followed by a convergent update. The block takes no new item while busy is high,
// and busy stays high until the final convergent update of the item. At most 48
// results are produced per item. The receiver cannot stall: each result
// must be taken in its cycle. Reset (synchronous, active high) returns the
// controller to idle and drops rsp_valid; no item is in flight after it.
module continued_fraction_convergents #(
   parameter int WIDTH = cfc_pkg::CFC_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_numerator,
   input  logic [5:0]  req_exponent,
   output logic        rsp_valid,
   output logic [32:0] rsp_quotient,
   output logic [31:0] rsp_conv_numer,
   output logic [32:0] rsp_conv_denom,
   output logic        rsp_candidate,
   output logic        rsp_last
);
   import cfc_pkg::*;

   cfc_cmd_type    cmd;
   cfc_status_type status;

   cfc_ctrl #(.WIDTH(WIDTH)) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   cfc_dp #(.WIDTH(WIDTH)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_numerator  (req_numerator),
      .req_exponent   (req_exponent),
      .rsp_valid      (rsp_valid),
      .rsp_quotient   (rsp_quotient),
      .rsp_conv_numer (rsp_conv_numer),
      .rsp_conv_denom (rsp_conv_denom),
      .rsp_candidate  (rsp_candidate),
      .rsp_last       (rsp_last)
   );
endmodule
